// ===== hdl/holonomic_velocity_rotate_clip_top_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the velocity rotate and clip block
// ---------------------------------------------------------------------------
`ifndef HOLONOMIC_VELOCITY_ROTATE_CLIP_TOP_ASSERT_SVH
`define HOLONOMIC_VELOCITY_ROTATE_CLIP_TOP_ASSERT_SVH

// property checked on every edge outside reset
`define HVRC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hvrc port check failed");

// property checked on every edge, reset included
`define HVRC_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hvrc reset check failed");

`endif

// ===== hdl/hvrc_pkg.sv =====
// ---------------------------------------------------------------------------
// hvrc_pkg
// types, constants and the arctangent table shared by the rotate/clip block
// ---------------------------------------------------------------------------
package hvrc_pkg;

  localparam int ANGLE_W = 16;
  localparam int VEL_W   = 16;
  localparam int RATE_W  = 17;
  localparam int LIM_W   = 15;
  localparam int CS_W    = 33;   // cos/sin q2.30 with headroom; residual angle with the full circle at 2^32
  localparam int PROD_W  = VEL_W + CS_W;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 104;
  localparam int ADDR_W  = 2;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [CS_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ANGLE_W:0] HALF_PI = 17'sd16384;
  localparam logic signed [ANGLE_W:0] PI_BAM  = 17'sd32768;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_LIMIT_VX    = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LIMIT_VY    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LIMIT_OMEGA = 2'd2;

  // one word moving through the rotator cells
  typedef struct packed {
    logic                     flip;
    logic signed [CS_W-1:0]   x;
    logic signed [CS_W-1:0]   y;
    logic signed [CS_W-1:0]   z;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic signed [VEL_W-1:0]  om;
  } hvrc_rot_t;

  typedef struct packed {
    logic [LIM_W-1:0] vx;
    logic [LIM_W-1:0] vy;
    logic [LIM_W-1:0] om;
  } hvrc_limits_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [5:0]               pad;
    logic signed [VEL_W-1:0]  clamped_omega;
    logic signed [VEL_W-1:0]  clamped_vy;
    logic signed [VEL_W-1:0]  clamped_vx;
    logic signed [VEL_W-1:0]  heading_rate;
    logic signed [RATE_W-1:0] y_rate;
    logic signed [RATE_W-1:0] x_rate;
  } hvrc_out_t;

  // atan(2^-i), full circle = 2^32
  function automatic logic [29:0] hvrc_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hvrc_cell.sv =====
// ---------------------------------------------------------------------------
// hvrc_cell
// one cordic rotation stage with its own valid/ready slot
// ---------------------------------------------------------------------------
module hvrc_cell import hvrc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  output logic      ready_o,
  input  hvrc_rot_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output hvrc_rot_t data_o
);

  localparam logic signed [CS_W-1:0] ATAN =
    signed'({3'b000, hvrc_atan(5'(STAGE))});

  logic             valid_r;
  hvrc_rot_t        data_r;
  hvrc_rot_t        data_nxt;
  logic signed [CS_W-1:0] dx;
  logic signed [CS_W-1:0] dy;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    dx       = data_i.y >>> STAGE;
    dy       = data_i.x >>> STAGE;
    data_nxt = data_i;
    // zero residual rotates the positive way
    if (!data_i.z[CS_W-1]) begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - ATAN;
    end else begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/hvrc_post.sv =====
// ---------------------------------------------------------------------------
// hvrc_post
// products, rounding, saturation and command clamps; holds the output word
// ---------------------------------------------------------------------------
module hvrc_post import hvrc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  hvrc_rot_t    data_i,
  input  hvrc_limits_t limits_i,
  output logic         valid_o,
  input  logic         ready_i,
  output hvrc_out_t    data_o
);

  localparam logic signed [PROD_W:0] RND_HALF = (PROD_W+1)'(64'sd536870912);
  localparam logic signed [PROD_W:0] SAT_HI   = (PROD_W+1)'(64'sd65535);
  localparam logic signed [PROD_W:0] SAT_LO   = -(PROD_W+1)'(64'sd65536);

  // product stage
  logic                     pa_valid_r;
  logic                     pa_ready;
  logic signed [PROD_W-1:0] p_vc_r, p_vs_r, p_uc_r, p_us_r;
  logic signed [VEL_W-1:0]  pa_vx_r, pa_vy_r, pa_om_r;
  logic signed [CS_W-1:0]   cos_v, sin_v;

  // output stage
  logic       out_valid_r;
  hvrc_out_t  out_r;
  hvrc_out_t  out_nxt;
  logic       out_ready;

  logic signed [PROD_W:0] sum_x, sum_y, rnd_x, rnd_y;

  assign out_ready = !out_valid_r || ready_i;
  assign pa_ready  = !pa_valid_r || out_ready;
  assign ready_o   = pa_ready;
  assign valid_o   = out_valid_r;
  assign data_o    = out_r;

  assign cos_v = data_i.flip ? -data_i.x : data_i.x;
  assign sin_v = data_i.flip ? -data_i.y : data_i.y;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [PROD_W:0] v);
    logic signed [RATE_W-1:0] r;
    if (v > SAT_HI)      r = 17'sd65535;
    else if (v < SAT_LO) r = -17'sd65536;
    else                 r = v[RATE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_sym(input logic signed [VEL_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [VEL_W:0] l;
    logic signed [VEL_W:0] vv;
    logic signed [VEL_W-1:0] r;
    l  = signed'({2'b00, lim});
    vv = (VEL_W+1)'(v);
    if (vv > l)       r = VEL_W'(lim);
    else if (vv < -l) r = VEL_W'(-l);
    else              r = v;
    return r;
  endfunction

  always_comb begin
    sum_x = (PROD_W+1)'(p_vc_r) - (PROD_W+1)'(p_us_r);
    sum_y = (PROD_W+1)'(p_vs_r) + (PROD_W+1)'(p_uc_r);
    rnd_x = (sum_x + RND_HALF) >>> 30;
    rnd_y = (sum_y + RND_HALF) >>> 30;
    out_nxt               = '0;
    out_nxt.x_rate        = sat_rate(rnd_x);
    out_nxt.y_rate        = sat_rate(rnd_y);
    out_nxt.heading_rate  = pa_om_r;
    out_nxt.clamped_vx    = clamp_sym(pa_vx_r, limits_i.vx);
    out_nxt.clamped_vy    = clamp_sym(pa_vy_r, limits_i.vy);
    out_nxt.clamped_omega = clamp_sym(pa_om_r, limits_i.om);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pa_ready)  pa_valid_r  <= valid_i;
      if (out_ready) out_valid_r <= pa_valid_r;
    end
    if (pa_ready && valid_i) begin
      p_vc_r  <= PROD_W'(data_i.vx) * PROD_W'(cos_v);
      p_vs_r  <= PROD_W'(data_i.vx) * PROD_W'(sin_v);
      p_uc_r  <= PROD_W'(data_i.vy) * PROD_W'(cos_v);
      p_us_r  <= PROD_W'(data_i.vy) * PROD_W'(sin_v);
      pa_vx_r <= data_i.vx;
      pa_vy_r <= data_i.vy;
      pa_om_r <= data_i.om;
    end
    if (out_ready && pa_valid_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/holonomic_velocity_rotate_clip_top.sv =====
// path: cordic cell row, then the product and output registers
// throughput: one word per cycle while out_tready is high, set by the pipelined
//   cordic cell row and the registered product stage; each stage holds one word
// a stalled output backs up stage by stage, bubbles are squeezed out
// reset: synchronous active-low rst_n empties every stage and loads all
//   three limits with 256 (1.0 in q8.8)
// ---------------------------------------------------------------------------
// holonomic_velocity_rotate_clip_top
// rotates body-frame velocity commands into the world frame by the heading
// and clamps each command to its configured limit
// ---------------------------------------------------------------------------
module holonomic_velocity_rotate_clip_top import hvrc_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // input word: heading[15:0], cmd_vx[31:16], cmd_vy[47:32], cmd_omega[63:48]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // result word: x_rate[16:0], y_rate[33:17], heading_rate[49:34],
  // clamped_vx[65:50], clamped_vy[81:66], clamped_omega[97:82], zero[103:98]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  // limit register writes
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [LIM_W-1:0]  cfg_wdata
);

  // table only covers 24 stages
  localparam int NCELL = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  hvrc_limits_t limits_r;

  // cell row links, index k feeds cell k
  logic      link_valid [NCELL+1];
  logic      link_ready [NCELL+1];
  hvrc_rot_t link_data  [NCELL+1];

  logic signed [ANGLE_W-1:0] heading;
  logic signed [ANGLE_W:0]   ang_ext;
  logic signed [ANGLE_W:0]   ang_fold;
  logic                      flip;
  hvrc_out_t                 out_word;

  assign heading = in_tdata[15:0];
  assign ang_ext = (ANGLE_W+1)'(heading);

  // fold into [-pi/2, pi/2]; the half-turn comes back as a sign flip
  always_comb begin
    flip     = 1'b0;
    ang_fold = ang_ext;
    if (ang_ext > HALF_PI) begin
      ang_fold = ang_ext - PI_BAM;
      flip     = 1'b1;
    end else if (ang_ext < -HALF_PI) begin
      ang_fold = ang_ext + PI_BAM;
      flip     = 1'b1;
    end
  end

  always_comb begin
    link_data[0].flip = flip;
    link_data[0].x    = GAIN_Q30;
    link_data[0].y    = '0;
    link_data[0].z    = {ang_fold, 16'h0000};
    link_data[0].vx   = in_tdata[31:16];
    link_data[0].vy   = in_tdata[47:32];
    link_data[0].om   = in_tdata[63:48];
  end

  assign link_valid[0] = in_tvalid;
  // nothing is taken while reset is held
  assign in_tready     = rst_n && link_ready[0];

  // row of rotation cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hvrc_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .data_i  (link_data[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .data_o  (link_data[k+1])
    );
  end

  // products, rounding, saturation, clamps and the output register
  hvrc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (link_valid[NCELL]),
    .ready_o  (link_ready[NCELL]),
    .data_i   (link_data[NCELL]),
    .limits_i (limits_r),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready),
    .data_o   (out_word)
  );

  assign out_tdata = out_word;

  // limit registers, unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.vx <= 15'd256;
      limits_r.vy <= 15'd256;
      limits_r.om <= 15'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LIMIT_VX:    limits_r.vx <= cfg_wdata;
        REG_LIMIT_VY:    limits_r.vy <= cfg_wdata;
        REG_LIMIT_OMEGA: limits_r.om <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/hvrc_checker.sv =====
// ---------------------------------------------------------------------------
// hvrc_checker
// port-level checks for the velocity rotate and clip block
// ---------------------------------------------------------------------------
`include "holonomic_velocity_rotate_clip_top_assert.svh"

module hvrc_checker import hvrc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic clamp_ok;

  // clamps are symmetric so the most negative code never shows, padding stays zero
  assign clamp_ok = out_tdata[65:50] != 16'h8000 && out_tdata[81:66] != 16'h8000 &&
                    out_tdata[97:82] != 16'h8000 && out_tdata[103:98] == 6'd0;

  // stalled word holds
  `HVRC_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // reset empties the output
  `HVRC_CHECK_RST(a_rst_empty, !rst_n |=> !out_tvalid)

  // an empty output register means the whole row can take a word
  `HVRC_CHECK(a_empty_ready, !out_tvalid |-> in_tready)

  `HVRC_CHECK(a_clamp_range, out_tvalid |-> clamp_ok)

endmodule

bind holonomic_velocity_rotate_clip_top hvrc_checker u_hvrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/hvrc_rate_check_pkg.sv =====
// ---------------------------------------------------------------------------
// hvrc_rate_check_pkg
// command word layout and a scoreboard that predicts the world-frame rates
// and clamped commands for every accepted command word
// ---------------------------------------------------------------------------
package hvrc_rate_check_pkg;
  import hvrc_pkg::*;

  // command word, last field in the lowest bits
  typedef struct packed {
    logic signed [VEL_W-1:0]   cmd_omega;
    logic signed [VEL_W-1:0]   cmd_vy;
    logic signed [VEL_W-1:0]   cmd_vx;
    logic signed [ANGLE_W-1:0] heading;
  } cmd_word_t;

  localparam longint ROT_GAIN   = 652032874;  // 0.60725293 in q2.30
  localparam int     MAX_STAGES = 24;

  class rate_tracker;
    int                errors;
    int                checked;
    int                stages;
    logic [LIM_W-1:0]  lim_vx;
    logic [LIM_W-1:0]  lim_vy;
    logic [LIM_W-1:0]  lim_om;
    longint            atan_step [MAX_STAGES];
    hvrc_out_t         pending_rates [$];

    function new(int n_stages);
      stages    = (n_stages > MAX_STAGES) ? MAX_STAGES : n_stages;
      // atan(2^-i) with the full circle at 2^32
      atan_step = '{536870912, 316933406, 167458907, 85004756,
                    42667331, 21354465, 10679838, 5340245,
                    2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861,
                    10430, 5215, 2608, 1304,
                    652, 326, 163, 81};
      lim_vx  = 15'd256;
      lim_vy  = 15'd256;
      lim_om  = 15'd256;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_limit(logic [ADDR_W-1:0] idx, logic [LIM_W-1:0] val);
      case (idx)
        REG_LIMIT_VX:    lim_vx = val;
        REG_LIMIT_VY:    lim_vy = val;
        REG_LIMIT_OMEGA: lim_om = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_rates.size();
    endfunction

    // q2.30 product back to q8.8, round half up, saturate to the rate range
    function logic signed [RATE_W-1:0] round_rate(longint p);
      longint v;
      v = (p + (64'sd1 <<< 29)) >>> 30;
      if (v < -65536) v = -65536;
      if (v > 65535) v = 65535;
      return v[RATE_W-1:0];
    endfunction

    function logic signed [VEL_W-1:0] clip(logic signed [VEL_W-1:0] v,
                                           logic [LIM_W-1:0] lim);
      longint l;
      longint r;
      l = lim;
      r = v;
      if (r > l) r = l;
      if (r < -l) r = -l;
      return r[VEL_W-1:0];
    endfunction

    function void note_command(cmd_word_t w);
      hvrc_out_t want;
      longint    a;
      longint    x;
      longint    y;
      longint    z;
      longint    dx;
      longint    dy;
      bit        flip;
      a    = w.heading;
      flip = 1'b0;
      // fold into [-pi/2, pi/2], negate cos and sin afterwards
      if (a > 16384) begin
        a = a - 32768;
        flip = 1'b1;
      end else if (a < -16384) begin
        a = a + 32768;
        flip = 1'b1;
      end
      x = ROT_GAIN;
      y = 0;
      z = a * 65536;
      for (int i = 0; i < stages; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_step[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_step[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      want               = '0;
      want.x_rate        = round_rate(longint'(w.cmd_vx) * x - longint'(w.cmd_vy) * y);
      want.y_rate        = round_rate(longint'(w.cmd_vx) * y + longint'(w.cmd_vy) * x);
      want.heading_rate  = w.cmd_omega;
      want.clamped_vx    = clip(w.cmd_vx, lim_vx);
      want.clamped_vy    = clip(w.cmd_vy, lim_vy);
      want.clamped_omega = clip(w.cmd_omega, lim_om);
      pending_rates.push_back(want);
    endfunction

    function void compare_field(string name, logic signed [RATE_W-1:0] want,
                                logic signed [RATE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hvrc_out_t got);
      hvrc_out_t want;
      if (pending_rates.size() == 0) begin
        $error("result word with no command pending");
        errors++;
        return;
      end
      want = pending_rates.pop_front();
      checked++;
      compare_field("x_rate", want.x_rate, got.x_rate);
      compare_field("y_rate", want.y_rate, got.y_rate);
      compare_field("heading_rate", want.heading_rate, got.heading_rate);
      compare_field("clamped_vx", want.clamped_vx, got.clamped_vx);
      compare_field("clamped_vy", want.clamped_vy, got.clamped_vy);
      compare_field("clamped_omega", want.clamped_omega, got.clamped_omega);
      compare_field("pad", want.pad, got.pad);
    endfunction
  endclass

endpackage

// ===== verif/holonomic_velocity_rotate_clip_top_tb.sv =====
// ---------------------------------------------------------------------------
// holonomic_velocity_rotate_clip_top_tb
// drives command words through the rotate/clip block under several limit
// settings with bursty input and a stalling receiver, and checks every result
// word field by field against a scoreboard prediction
// ---------------------------------------------------------------------------
module holonomic_velocity_rotate_clip_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hvrc_pkg::*;
  import hvrc_rate_check_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int BATCH_WORDS   = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = CORDIC_STAGES + 6;

  // index past the register list, writes there must be ignored
  localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_addr   = '0;
  logic [LIM_W-1:0]  cfg_wdata  = '0;

  rate_tracker      book;
  stall_mode_t      stall_mode  = STALL_NONE;
  int               stall_phase = 0;
  int               cycles      = 0;
  int               words_sent  = 0;
  int               limit_writes = 0;
  logic [LIM_W-1:0] cur_lim [3] = '{15'd256, 15'd256, 15'd256};

  holonomic_velocity_rotate_clip_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // heading, cmd_vx, cmd_vy, cmd_omega
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // x_rate, y_rate, heading_rate, clamped_vx/vy/omega, pad
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) book.note_command(in_tdata);
      if (out_tvalid && out_tready) book.check_result(out_tdata);
    end
  end

  // receiver back-pressure, pattern picked per batch
  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: out_tready <= 1'b1;
      STALL_COIN: out_tready <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: begin
        // ready while the phase counter is below five, stalled otherwise
        stall_phase = (stall_phase + 1) % 8;
        out_tready <= (stall_phase < 5);
      end
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // heading mostly uniform, sometimes right on a fold boundary
  function automatic logic [ANGLE_W-1:0] pick_heading();
    int v;
    if ($urandom_range(0, 7) != 0) begin
      v = int'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 6))
        0: v = -32768;   // exactly -pi
        1: v = 32767;
        2: v = 16384;    // +pi/2, no fold
        3: v = -16384;
        4: v = 16385;    // first angle that folds
        5: v = -16385;
        default: v = 0;
      endcase
    end
    return v[ANGLE_W-1:0];
  endfunction

  // velocity command: uniform, around the current limit, extremes or small
  function automatic logic [VEL_W-1:0] pick_cmd(logic [LIM_W-1:0] lim);
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = int'($urandom_range(0, 65535)) - 32768;
      2: begin
        v = int'(lim) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 2))
          0: v = -32768;
          1: v = 32767;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(0, 2047)) - 1024;
    endcase
    return v[VEL_W-1:0];
  endfunction

  task automatic send_word(input cmd_word_t w);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic write_limit(input logic [ADDR_W-1:0] idx, input logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_limit(idx, val);
    if (idx != REG_UNUSED) cur_lim[idx] = val;
    limit_writes++;
  endtask

  task automatic write_limits(input logic [LIM_W-1:0] vx, input logic [LIM_W-1:0] vy,
                              input logic [LIM_W-1:0] om);
    write_limit(REG_LIMIT_VX, vx);
    write_limit(REG_LIMIT_VY, vy);
    write_limit(REG_LIMIT_OMEGA, om);
  endtask

  // random batch, optionally in bursts with idle gaps between them
  task automatic run_batch(input int count, input bit bursty);
    cmd_word_t w;
    int        burst_left;
    int        gap;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      w.heading   = pick_heading();
      w.cmd_vx    = pick_cmd(cur_lim[REG_LIMIT_VX]);
      w.cmd_vy    = pick_cmd(cur_lim[REG_LIMIT_VY]);
      w.cmd_omega = pick_cmd(cur_lim[REG_LIMIT_OMEGA]);
      if (bursty) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            @(negedge clk);
            in_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        burst_left--;
      end
      send_word(w);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait for every expected word, then let the pipe run dry
  task automatic settle();
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cmd_word_t directed [$];
    book = new(CORDIC_STAGES);

    // fields: cmd_omega, cmd_vy, cmd_vx, heading
    directed = '{
      '{16'sd0,      16'sd0,      16'sd256,    16'sd0},      // zero heading, identity
      '{16'sd256,    16'sd0,      16'sd0,      16'sd16384},  // quarter turn, omega at the limit
      '{-16'sd256,   16'sd256,    16'sd0,      -16'sd16384},
      '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767},  // all at max
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, // all at min, heading -pi
      '{16'sd257,    -16'sd100,   16'sd100,    16'sd16385},  // just past the fold
      '{-16'sd257,   16'sd100,    -16'sd100,   -16'sd16385},
      '{16'sd1,      -16'sd32768, 16'sd32767,  16'sd8192},   // 45 deg, largest rate
      '{-16'sd1,     16'sd32767,  -16'sd32768, -16'sd8192},
      '{16'sd0,      16'sd32767,  16'sd32767,  16'sd24576},
      '{16'sd255,    16'sd32767,  -16'sd32768, -16'sd24576},
      '{16'sd0,      16'sd0,      16'sd1000,   -16'sd32768}, // -pi with a vector along x
      '{-16'sd1,     -16'sd1,     -16'sd1,     16'sd1},
      '{16'sd1,      16'sd1,      16'sd1,      -16'sd1},
      '{16'sd0,      16'sd0,      16'sd0,      16'sd0},
      '{16'sd0,      -16'sd32768, 16'sd32767,  16'sd0},
      '{-16'sd21846, 16'sd12345,  -16'sd4321,  16'sd20000}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset limits, no idling on either side
    stall_mode = STALL_NONE;
    foreach (directed[i]) send_word(directed[i]);
    @(negedge clk);
    in_tvalid <= 1'b0;
    settle();

    // all limits zero: every clamped field collapses to zero
    write_limits(15'd0, 15'd0, 15'd0);
    stall_mode = STALL_COIN;
    run_batch(BATCH_WORDS, 1'b1);
    settle();

    // widest limits, steady sender against a periodic stall
    write_limits(15'd32767, 15'd32767, 15'd32767);
    stall_mode = STALL_PERIODIC;
    run_batch(BATCH_WORDS, 1'b0);
    settle();

    write_limits(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                 15'($urandom_range(0, 32767)));
    stall_mode = STALL_HEAVY;
    run_batch(BATCH_WORDS, 1'b1);
    settle();

    write_limits(15'($urandom_range(0, 600)), 15'($urandom_range(0, 600)),
                 15'($urandom_range(0, 600)));
    stall_mode = STALL_NONE;
    run_batch(BATCH_WORDS, 1'b1);
    settle();

    // mixed extremes, then a write past the register list that must not stick
    write_limits(15'd1, 15'd32767, 15'd0);
    write_limit(REG_UNUSED, 15'($urandom_range(0, 32767)));
    stall_mode = STALL_COIN;
    run_batch(BATCH_WORDS, 1'b1);
    settle();

    write_limits(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                 15'($urandom_range(0, 32767)));
    stall_mode = STALL_PERIODIC;
    run_batch(BATCH_WORDS, 1'b1);
    settle();

    $display("%0d command words over %0d limit writes, %0d result words checked",
             words_sent, limit_writes, book.checked);
    $display("%0d mismatches, run took %0d cycles", book.errors, cycles);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hvrc_pkg.sv
hdl/hvrc_cell.sv
hdl/hvrc_post.sv
hdl/holonomic_velocity_rotate_clip_top.sv
hdl/hvrc_checker.sv
verif/hvrc_rate_check_pkg.sv
verif/holonomic_velocity_rotate_clip_top_tb.sv
